[rtl/hvp_pkg.sv]
`default_nettype none
package hvp_pkg;

   // Field widths
   localparam int H_W        = 24;
   localparam int PRIOR_W    = 16;
   localparam int SCALE_W    = 15;
   localparam int RHO_W      = 23;
   localparam int LAM_W      = 23;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 23;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_SQ  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RHO_LEVEL = 2'd1;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 15'd4096;
   localparam logic [RHO_W-1:0]   RHO_RESET   = 23'd0;

   localparam logic [PRIOR_W-1:0] ONE_Q15     = 16'd32768;
   localparam logic [28:0]        SMALL_LIMIT = 29'd105;
   localparam logic [LAM_W-1:0]   LAM_MAX     = 23'h7FFFFF;

   // Pipeline depths
   localparam int SQ_STEPS  = 28;
   localparam int DIV_STEPS = 30;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   typedef struct packed {
      logic signed [H_W-1:0] hxx;
      logic signed [H_W-1:0] hyy;
      logic signed [H_W-1:0] hxy;
      logic [PRIOR_W-1:0]    prior_best;
   } hvp_req_type;

   typedef struct packed {
      logic signed [H_W-1:0] neg_lambda;
      logic [PRIOR_W-1:0]    response;
      logic [PRIOR_W-1:0]    best;
   } hvp_rsp_type;

   // Item handed from front to back: clamped eigenvalue and clamped prior
   typedef struct packed {
      logic [LAM_W-1:0]   lam;
      logic [PRIOR_W-1:0] prior;
   } hvp_item_type;

endpackage
`default_nettype wire

[rtl/hvp_front.sv]
`default_nettype none
module hvp_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [hvp_pkg::SCALE_W-1:0]   scale_sq,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  hvp_pkg::hvp_req_type          in_data,
   output logic                          push,
   output hvp_pkg::hvp_item_type         push_data,
   input  logic                          queue_full
);
   import hvp_pkg::*;

   localparam int FE_STAGES = SQ_STEPS + 4;

   logic [FE_STAGES-1:0] vld_ff;
   logic                 advance;

   // Stage 1: scaled entries
   logic signed [26:0]  a_ff, b_ff, c_ff, a_in, b_in, c_in;
   logic [PRIOR_W-1:0]  pr1_ff, pr1_in;
   // Stage 2: trace, mask, squares
   logic signed [27:0]  t2_ff, t2_in, d2;
   logic                mk2_ff, mk2_in;
   logic [54:0]         dsq_ff, dsq_in;
   logic [52:0]         csq_ff, csq_in;
   logic [PRIOR_W-1:0]  pr2_ff;
   logic signed [55:0]  dprod;
   logic signed [53:0]  cprod;
   // Stage 3: discriminant
   logic [55:0]         dd3_ff, dd3_in;
   logic signed [27:0]  t3_ff;
   logic                mk3_ff;
   logic [PRIOR_W-1:0]  pr3_ff;
   // Square root stages
   logic [29:0]         rem_ff [SQ_STEPS];
   logic [29:0]         rem_in [SQ_STEPS];
   logic [27:0]         root_ff [SQ_STEPS];
   logic [27:0]         root_in [SQ_STEPS];
   logic [55:0]         rad_ff [SQ_STEPS];
   logic signed [27:0]  tq_ff [SQ_STEPS];
   logic                mq_ff [SQ_STEPS];
   logic [PRIOR_W-1:0]  pq_ff [SQ_STEPS];
   logic [29:0]         src_rem [SQ_STEPS];
   logic [27:0]         src_root [SQ_STEPS];
   logic [55:0]         src_rad [SQ_STEPS];
   logic [31:0]         cur, trial;
   // Output stage
   hvp_item_type        out_ff, out_in;
   logic signed [29:0]  n_val, lam_raw;

   // Stall the whole front only when its last item cannot be pushed
   assign advance  = !queue_full || !vld_ff[FE_STAGES-1];
   assign in_ready = advance;
   assign push     = vld_ff[FE_STAGES-1] && !queue_full;
   assign push_data = out_ff;

   // Scale each entry, round half up, and clamp the prior to one
   always_comb begin
      logic signed [39:0] pa, pb, pc;
      pa = in_data.hxx * $signed({1'b0, scale_sq}) + 40'sd2048;
      pb = in_data.hyy * $signed({1'b0, scale_sq}) + 40'sd2048;
      pc = in_data.hxy * $signed({1'b0, scale_sq}) + 40'sd2048;
      a_in = pa[38:12];
      b_in = pb[38:12];
      c_in = pc[38:12];
      pr1_in = (in_data.prior_best > ONE_Q15) ? ONE_Q15 : in_data.prior_best;
   end

   // Trace, mask and the two squares
   always_comb begin
      t2_in  = {a_ff[26], a_ff} + {b_ff[26], b_ff};
      d2     = {a_ff[26], a_ff} - {b_ff[26], b_ff};
      mk2_in = (t2_in > 28'sd0) || (t2_in == 28'sd0 && a_ff == 27'sd0 && c_ff == 27'sd0);
      dprod  = d2 * d2;
      cprod  = c_ff * c_ff;
      dsq_in = dprod[54:0];
      csq_in = cprod[52:0];
   end

   assign dd3_in = {1'b0, dsq_ff} + {1'b0, csq_ff, 2'b00};

   // One root bit per stage
   always_comb begin
      src_rem[0]  = '0;
      src_root[0] = '0;
      src_rad[0]  = dd3_ff;
      for (int k = 1; k < SQ_STEPS; k++) begin
         src_rem[k]  = rem_ff[k-1];
         src_root[k] = root_ff[k-1];
         src_rad[k]  = rad_ff[k-1];
      end
      cur   = '0;
      trial = '0;
      for (int k = 0; k < SQ_STEPS; k++) begin
         cur   = {src_rem[k], src_rad[k][55-2*k -: 2]};
         trial = {2'b00, src_root[k], 2'b01};
         if (cur >= trial) begin
            rem_in[k]  = 30'(cur - trial);
            root_in[k] = {src_root[k][26:0], 1'b1};
         end else begin
            rem_in[k]  = cur[29:0];
            root_in[k] = {src_root[k][26:0], 1'b0};
         end
      end
   end

   // Form L, flush small values, clamp
   always_comb begin
      n_val   = $signed({2'b00, root_ff[SQ_STEPS-1]}) - {{2{tq_ff[SQ_STEPS-1][27]}},
                tq_ff[SQ_STEPS-1]};
      lam_raw = (n_val + 30'sd1) >>> 1;
      out_in.prior = pq_ff[SQ_STEPS-1];
      if (mq_ff[SQ_STEPS-1] || lam_raw[29] || lam_raw[28:0] < SMALL_LIMIT) begin
         out_in.lam = '0;
      end else if (lam_raw[28:23] != 6'd0) begin
         out_in.lam = LAM_MAX;
      end else begin
         out_in.lam = lam_raw[22:0];
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[FE_STAGES-2:0], in_valid};
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (advance) begin
         a_ff   <= a_in;
         b_ff   <= b_in;
         c_ff   <= c_in;
         pr1_ff <= pr1_in;
         t2_ff  <= t2_in;
         mk2_ff <= mk2_in;
         dsq_ff <= dsq_in;
         csq_ff <= csq_in;
         pr2_ff <= pr1_ff;
         dd3_ff <= dd3_in;
         t3_ff  <= t2_ff;
         mk3_ff <= mk2_ff;
         pr3_ff <= pr2_ff;
         for (int k = 0; k < SQ_STEPS; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            rad_ff[k]  <= src_rad[k];
            tq_ff[k]   <= (k == 0) ? t3_ff  : tq_ff[(k == 0) ? 0 : k-1];
            mq_ff[k]   <= (k == 0) ? mk3_ff : mq_ff[(k == 0) ? 0 : k-1];
            pq_ff[k]   <= (k == 0) ? pr3_ff : pq_ff[(k == 0) ? 0 : k-1];
         end
         out_ff <= out_in;
      end
   end

endmodule
`default_nettype wire

[rtl/hvp_queue.sv]
`default_nettype none
module hvp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  hvp_pkg::hvp_item_type  push_data,
   output logic                   full,
   input  logic                   pop,
   output hvp_pkg::hvp_item_type  pop_data,
   output logic                   not_empty
);
   import hvp_pkg::*;

   hvp_item_type           mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   // Move pointers and count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed item
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> not_empty)
      else $error("queue pop while empty");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> count_ff == $past(count_ff) + QUEUE_CNT_W'($past(push))
                                   - QUEUE_CNT_W'($past(pop)))
      else $error("queue count mismatch");
`endif

endmodule
`default_nettype wire

[rtl/hvp_back.sv]
`default_nettype none
module hvp_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [hvp_pkg::RHO_W-1:0]   rho_level,
   input  logic                        in_valid,
   output logic                        pop,
   input  hvp_pkg::hvp_item_type       in_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output hvp_pkg::hvp_rsp_type        rsp_data
);
   import hvp_pkg::*;

   localparam int BK_STAGES = DIV_STEPS + 4;
   localparam logic [1:0] CODE_ZERO  = 2'd0;
   localparam logic [1:0] CODE_ONE   = 2'd1;
   localparam logic [1:0] CODE_RATIO = 2'd2;

   logic [BK_STAGES-1:0] vld_ff;
   logic                 advance;

   // Classify stage
   logic [LAM_W-1:0]   lam0_ff;
   logic [PRIOR_W-1:0] pr0_ff;
   logic [1:0]         code0_ff, code0_in;
   logic [23:0]        u0_ff, u0_in;
   // Divider stages
   logic [23:0]        drem_ff [DIV_STEPS];
   logic [23:0]        drem_in [DIV_STEPS];
   logic [29:0]        dq_ff [DIV_STEPS];
   logic [29:0]        dq_in [DIV_STEPS];
   logic [23:0]        du_ff [DIV_STEPS];
   logic [LAM_W-1:0]   dl_ff [DIV_STEPS];
   logic [PRIOR_W-1:0] dp_ff [DIV_STEPS];
   logic [1:0]         dc_ff [DIV_STEPS];
   logic [23:0]        src_rem [DIV_STEPS];
   logic [29:0]        src_q [DIV_STEPS];
   logic [23:0]        src_u [DIV_STEPS];
   logic [24:0]        cur;
   // Multiply stages
   logic [59:0]        pp;
   logic [29:0]        t1_ff;
   logic [30:0]        m_ff, m_in;
   logic [LAM_W-1:0]   l1_ff, l2_ff;
   logic [PRIOR_W-1:0] p1_ff, p2_ff;
   logic [1:0]         c1_ff, c2_ff;
   logic [60:0]        tm;
   logic [30:0]        t2_ff;
   // Output register
   hvp_rsp_type        out_ff, out_in;
   logic [35:0]        r27;
   logic [PRIOR_W-1:0] resp;

   // Stall the back only on a waiting result
   assign advance   = !vld_ff[BK_STAGES-1] || rsp_ready;
   assign pop       = advance && in_valid;
   assign rsp_valid = vld_ff[BK_STAGES-1];
   assign rsp_data  = out_ff;

   // Pick the special case
   always_comb begin
      u0_in = {1'b0, in_data.lam} + {1'b0, rho_level};
      if (in_data.lam == '0) begin
         code0_in = CODE_ZERO;
      end else if ({in_data.lam, 1'b0} >= {1'b0, rho_level}) begin
         code0_in = CODE_ONE;
      end else begin
         code0_in = CODE_RATIO;
      end
   end

   // One quotient bit per stage of L * 2^30 / (L + rho)
   always_comb begin
      src_rem[0] = {1'b0, lam0_ff};
      src_q[0]   = '0;
      src_u[0]   = u0_ff;
      for (int k = 1; k < DIV_STEPS; k++) begin
         src_rem[k] = drem_ff[k-1];
         src_q[k]   = dq_ff[k-1];
         src_u[k]   = du_ff[k-1];
      end
      cur = '0;
      for (int k = 0; k < DIV_STEPS; k++) begin
         cur = {src_rem[k], 1'b0};
         if (cur >= {1'b0, src_u[k]}) begin
            drem_in[k] = 24'(cur - {1'b0, src_u[k]});
            dq_in[k]   = {src_q[k][28:0], 1'b1};
         end else begin
            drem_in[k] = cur[23:0];
            dq_in[k]   = {src_q[k][28:0], 1'b0};
         end
      end
   end

   // Square the ratio, form 1 - 2p
   assign pp   = dq_ff[DIV_STEPS-1] * dq_ff[DIV_STEPS-1];
   assign m_in = 31'h40000000 - {dq_ff[DIV_STEPS-1], 1'b0};
   assign tm   = t1_ff * m_ff;

   // Scale by 27, clamp, select and take the maximum
   always_comb begin
      r27 = t2_ff * 36'd27;
      case (c2_ff)
         CODE_ZERO:  resp = '0;
         CODE_ONE:   resp = ONE_Q15;
         CODE_RATIO: resp = (r27[35:15] > {5'd0, ONE_Q15}) ? ONE_Q15 : r27[30:15];
         default:    resp = '0;
      endcase
      out_in.neg_lambda = {1'b0, l2_ff};
      out_in.response   = resp;
      out_in.best       = (p2_ff > resp) ? p2_ff : resp;
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[BK_STAGES-2:0], in_valid};
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (advance) begin
         lam0_ff  <= in_data.lam;
         pr0_ff   <= in_data.prior;
         code0_ff <= code0_in;
         u0_ff    <= u0_in;
         for (int k = 0; k < DIV_STEPS; k++) begin
            drem_ff[k] <= drem_in[k];
            dq_ff[k]   <= dq_in[k];
            du_ff[k]   <= src_u[k];
            dl_ff[k]   <= (k == 0) ? lam0_ff  : dl_ff[(k == 0) ? 0 : k-1];
            dp_ff[k]   <= (k == 0) ? pr0_ff   : dp_ff[(k == 0) ? 0 : k-1];
            dc_ff[k]   <= (k == 0) ? code0_ff : dc_ff[(k == 0) ? 0 : k-1];
         end
         t1_ff  <= pp[59:30];
         m_ff   <= m_in;
         l1_ff  <= dl_ff[DIV_STEPS-1];
         p1_ff  <= dp_ff[DIV_STEPS-1];
         c1_ff  <= dc_ff[DIV_STEPS-1];
         t2_ff  <= tm[60:30];
         l2_ff  <= l1_ff;
         p2_ff  <= p1_ff;
         c2_ff  <= c1_ff;
         out_ff <= out_in;
      end
   end

endmodule
`default_nettype wire

[rtl/hessian_vesselness_pixel_core.sv]
// Per-pixel 2-D Hessian vesselness: takes Hxx, Hyy, Hxy (signed Q3.20) and an earlier
// best response, and returns the negated smaller eigenvalue, this scale's response
// and the running best. The core takes one item per clock while req_ready is high and
// returns one result per item, in order. A 32-stage front (scaling, squares and a
// square root that settles one root bit per stage) feeds a four-entry item queue and a
// 34-stage back (a classify stage, a divider that settles one quotient bit per stage,
// two multiply stages and the output register). Results stall at the output register;
// the queue lets the front keep taking items while the back waits, until it fills.
// Write scale_sq (index 0) and rho_level (index 1) only while no item is in flight.
`default_nettype none
module hessian_vesselness_pixel_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  hvp_pkg::hvp_req_type            req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output hvp_pkg::hvp_rsp_type            rsp_data,
   input  logic                            csr_write_en,
   input  logic [hvp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hvp_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import hvp_pkg::*;

   logic [SCALE_W-1:0] scale_sq_ff;
   logic [RHO_W-1:0]   rho_level_ff;
   logic               push, full, pop, not_empty;
   hvp_item_type       push_data, pop_data;

   // Hold configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_sq_ff  <= SCALE_RESET;
         rho_level_ff <= RHO_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SCALE_SQ:  scale_sq_ff  <= csr_wdata[SCALE_W-1:0];
            CSR_RHO_LEVEL: rho_level_ff <= csr_wdata[RHO_W-1:0];
            default:       ;
         endcase
      end
   end

   hvp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .scale_sq   (scale_sq_ff),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_data    (req_data),
      .push       (push),
      .push_data  (push_data),
      .queue_full (full)
   );

   hvp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .not_empty (not_empty)
   );

   hvp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rho_level (rho_level_ff),
      .in_valid  (not_empty),
      .pop       (pop),
      .in_data   (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
